### hw/rtl/csm_pkg.sv
package csm_pkg;

  localparam int MAX_PATTERN_DEF = 16;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_TEXT   = 2'd2,
    ACT_END    = 2'd3
  } action_t;

  typedef struct packed {
    action_t    action;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic found;
    logic pattern_overflow;
  } result_t;

  // Word handed from the input register to the matcher when it is consumed.
  typedef struct packed {
    logic       go;
    action_t    action;
    logic [7:0] data_byte;
  } cmd_t;

  typedef struct packed {
    logic found;
    logic overflow;
  } status_t;

  // ASCII upper-case letters fold to lower case; every other value passes.
  function automatic logic [7:0] fold_case(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= 8'h41 && b <= 8'h5A) begin
      r = b + 8'h20;
    end
    return r;
  endfunction

endpackage

### hw/rtl/csm_matcher.sv
module csm_matcher #(
  parameter int MAX_PATTERN = csm_pkg::MAX_PATTERN_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  csm_pkg::cmd_t    cmd,
  output csm_pkg::status_t status
);
  import csm_pkg::*;

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);

  // The pattern is held newest byte first, so entry w always lines up with
  // window entry w and every compare sits at a fixed place.
  logic [7:0]       pattern_rev [MAX_PATTERN];
  logic [7:0]       text_window [MAX_PATTERN];
  logic [7:0]       window_next [MAX_PATTERN];
  logic [LEN_W-1:0] pattern_length;
  logic [LEN_W-1:0] text_seen;
  logic [LEN_W-1:0] text_seen_next;
  logic             match_flag;
  logic             overflow_flag;
  logic [7:0]       folded;
  logic [MAX_PATTERN-1:0] hit;
  logic             window_match;
  logic             pattern_full;
  logic             do_append;
  logic             do_text;

  assign folded       = fold_case(cmd.data_byte);
  assign pattern_full = (pattern_length == LEN_W'(MAX_PATTERN));
  assign do_append    = cmd.go && (cmd.action == ACT_APPEND) && !pattern_full;
  assign do_text      = cmd.go && (cmd.action == ACT_TEXT);

  assign text_seen_next = (text_seen == LEN_W'(MAX_PATTERN)) ? text_seen
                                                             : text_seen + 1'b1;

  assign window_next[0] = folded;
  for (genvar k = 1; k < MAX_PATTERN; k++) begin : g_wnext
    assign window_next[k] = text_window[k-1];
  end

  for (genvar w = 0; w < MAX_PATTERN; w++) begin : g_cmp
    assign hit[w] = (LEN_W'(w) >= pattern_length) || (window_next[w] == pattern_rev[w]);
  end

  assign window_match = (pattern_length != '0) && (text_seen_next >= pattern_length) && (&hit);

  always_ff @(posedge clk) begin
    if (do_append) begin
      pattern_rev[0] <= folded;
    end
    if (do_text) begin
      text_window[0] <= folded;
    end
  end

  for (genvar k = 1; k < MAX_PATTERN; k++) begin : g_shift
    always_ff @(posedge clk) begin
      if (do_append) begin
        pattern_rev[k] <= pattern_rev[k-1];
      end
      if (do_text) begin
        text_window[k] <= text_window[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= '0;
      text_seen      <= '0;
      match_flag     <= 1'b0;
      overflow_flag  <= 1'b0;
    end else if (cmd.go) begin
      unique case (cmd.action)
        ACT_CLEAR: begin
          pattern_length <= '0;
          text_seen      <= '0;
          match_flag     <= 1'b0;
          overflow_flag  <= 1'b0;
        end
        ACT_APPEND: begin
          if (pattern_full) begin
            overflow_flag <= 1'b1;
          end else begin
            pattern_length <= pattern_length + 1'b1;
          end
        end
        ACT_TEXT: begin
          text_seen <= text_seen_next;
          if (window_match) begin
            match_flag <= 1'b1;
          end
        end
        ACT_END: begin
          text_seen  <= '0;
          match_flag <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // An empty pattern matches any text, the empty one included.
  assign status.found    = match_flag || (pattern_length == '0);
  assign status.overflow = overflow_flag;

endmodule

### hw/rtl/caseless_substring_matcher.sv
// Caseless substring matcher.
// An item is registered on acceptance and then acted on; an end word's
// result is registered once the result slot frees. Throughput: one word per cycle,
// set by the parallel window compare, while no end word waits for the result slot.
// Reset (rst, synchronous, active high) empties both registers and clears the
// pattern length, text count and flags; the byte stores are not cleared.
module caseless_substring_matcher #(
  parameter int MAX_PATTERN = csm_pkg::MAX_PATTERN_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  csm_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output csm_pkg::result_t result
);
  import csm_pkg::*;

  item_t   in_q;
  logic    in_full;
  result_t out_q;
  logic    out_full;
  logic    out_free;
  logic    stage_go;
  cmd_t    cmd;
  status_t status;

  // An end word waits in the input register until the result slot frees up;
  // every other word moves on at once.
  assign out_free   = !out_full || result_ready;
  assign stage_go   = in_full && ((in_q.action != ACT_END) || out_free);
  assign item_ready = !in_full || stage_go;

  assign cmd.go        = stage_go;
  assign cmd.action    = in_q.action;
  assign cmd.data_byte = in_q.data_byte;

  csm_matcher #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_matcher (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .status (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (item_valid && item_ready) begin
      in_full <= 1'b1;
    end else if (stage_go) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      in_q <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (stage_go && (in_q.action == ACT_END)) begin
      out_full <= 1'b1;
    end else if (result_ready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_go && (in_q.action == ACT_END)) begin
      out_q.found            <= status.found;
      out_q.pattern_overflow <= status.overflow;
    end
  end

  assign result_valid = out_full;
  assign result       = out_q;

endmodule
